// File: rtl/shared_buffer_multi_queue_unit_assert.svh
// assertion macros used by rtl/shared_buffer_multi_queue_unit.sv
`ifndef SHARED_BUFFER_MULTI_QUEUE_UNIT_ASSERT_SVH
`define SHARED_BUFFER_MULTI_QUEUE_UNIT_ASSERT_SVH

`ifndef ASSERT_OFF
// same-cycle implication, checked on every rising clock edge outside reset
`define SBMQ_ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// next-cycle implication
`define SBMQ_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define SBMQ_ASSERT_SAME(lbl, clk, rst, ante, cons, msg)
`define SBMQ_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)
`endif

`endif

// File: rtl/sbmq_pkg.sv
package sbmq_pkg;

   // defaults for the top-level parameters
   localparam int SLOTS_DEFAULT  = 64;
   localparam int QUEUES_DEFAULT = 4;

   // field widths
   localparam int QSEL_W   = 2;
   localparam int VALUE_W  = 32;
   localparam int STATUS_W = 2;

   // stream packing
   localparam int REQ_TDATA_W = 40;
   localparam int QSEL_LSB    = 0;
   localparam int VALUE_LSB   = QSEL_LSB + QSEL_W;
   localparam int RSP_TDATA_W = VALUE_W;

   typedef enum logic {
      OP_ENQUEUE = 1'b0,
      OP_DEQUEUE = 1'b1
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_DONE  = 2'd0,
      ST_FULL  = 2'd1,
      ST_EMPTY = 2'd2
   } status_type;

endpackage

// File: rtl/sbmq_ram.sv
module sbmq_ram #(
   parameter int WIDTH  = 32,
   parameter int DEPTH  = 64,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // read data holds until the next read
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

// File: rtl/shared_buffer_multi_queue_unit.sv
// channel   dir  tdata                                   tuser
// req       in   queue_select [1:0], value [33:2], zeros  operation [0]
// rsp       out  data [31:0]                             status [1:0]
//
// each item reads the link and slot rams in its transfer cycle;
// the write-back after it writes them back and loads the result register
// the write-back depends on the registered ram read of the transfer cycle
// a stalled result holds the write-back cycle; a new item is taken as soon as
// the write-back is done, while the previous result may still wait on rsp
// reset is synchronous; the link ram needs no clearing pass since a fill count
// marks the slots never allocated, whose link is taken as slot i -> i + 1
`include "shared_buffer_multi_queue_unit_assert.svh"

module shared_buffer_multi_queue_unit #(
   parameter int SLOTS  = sbmq_pkg::SLOTS_DEFAULT,
   parameter int QUEUES = sbmq_pkg::QUEUES_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // queue_select [1:0], value [33:2], zero fill [39:34]
   input  logic [sbmq_pkg::REQ_TDATA_W-1:0]   req_tdata,
   // operation [0]
   input  logic                               req_tuser,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // data [31:0]
   output logic [sbmq_pkg::RSP_TDATA_W-1:0]   rsp_tdata,
   // status [1:0]
   output logic [sbmq_pkg::STATUS_W-1:0]      rsp_tuser
);

   // pointer width holds the null code, which is SLOTS itself
   localparam int PTR_W  = $clog2(SLOTS + 1);
   localparam int ADDR_W = $clog2(SLOTS);
   localparam logic [PTR_W-1:0] NIL = PTR_W'(SLOTS);
   // only queues the select field can reach get registers
   localparam int QREG   = (QUEUES < (1 << sbmq_pkg::QSEL_W)) ? QUEUES
                                                              : (1 << sbmq_pkg::QSEL_W);
   localparam int QIDX_W = (QREG > 1) ? $clog2(QREG) : 1;

   // queue pointers and free list
   logic [PTR_W-1:0] head_ff [QREG];
   logic [PTR_W-1:0] head_in [QREG];
   logic [PTR_W-1:0] tail_ff [QREG];
   logic [PTR_W-1:0] tail_in [QREG];
   logic [PTR_W-1:0] free_head_ff, free_head_in;
   // slots at or above the fill count were never allocated
   logic [PTR_W-1:0] fill_ff, fill_in;

   // item in write-back
   logic                               busy_ff, busy_in;
   sbmq_pkg::op_type                   op_ff;
   logic                               ok_ff;
   logic [QIDX_W-1:0]                  qi_ff;
   logic signed [sbmq_pkg::VALUE_W-1:0] value_ff;

   // result register
   logic                                rsp_valid_ff, rsp_valid_in;
   logic signed [sbmq_pkg::VALUE_W-1:0] rsp_data_ff, rsp_data_in;
   sbmq_pkg::status_type                rsp_status_ff, rsp_status_in;

   // transfer side decode
   logic                                req_fire;
   sbmq_pkg::op_type                    req_op;
   logic [sbmq_pkg::QSEL_W-1:0]         req_q;
   logic signed [sbmq_pkg::VALUE_W-1:0] req_value;
   logic [QIDX_W-1:0]                   req_qi;
   logic                                q_valid;
   logic [PTR_W-1:0]                    sel_head;
   logic                                req_ok;

   // ram ports
   logic                         link_we;
   logic [ADDR_W-1:0]            link_wa;
   logic [PTR_W-1:0]             link_wd;
   logic [ADDR_W-1:0]            link_ra;
   logic [PTR_W-1:0]             link_rd;
   logic                         data_we;
   logic [ADDR_W-1:0]            data_wa;
   logic [ADDR_W-1:0]            data_ra;
   logic [sbmq_pkg::VALUE_W-1:0] data_rd;

   // write-back side
   logic             done;
   logic [PTR_W-1:0] cur_head;
   logic [PTR_W-1:0] cur_tail;

   assign req_tready = !busy_ff;
   assign req_fire   = req_tvalid && req_tready;
   assign req_op     = sbmq_pkg::op_type'(req_tuser);
   assign req_q      = req_tdata[sbmq_pkg::QSEL_LSB +: sbmq_pkg::QSEL_W];
   assign req_value  = signed'(req_tdata[sbmq_pkg::VALUE_LSB +: sbmq_pkg::VALUE_W]);
   assign req_qi     = QIDX_W'(req_q);
   assign q_valid    = (32'(req_q) < QUEUES);
   assign sel_head   = q_valid ? head_ff[req_qi] : NIL;

   // a nonexistent queue reports full on enqueue and empty on dequeue
   always_comb begin
      if (req_op == sbmq_pkg::OP_ENQUEUE) begin
         req_ok  = q_valid && (free_head_ff < NIL);
         link_ra = ADDR_W'(free_head_ff);
      end else begin
         req_ok  = q_valid && (sel_head < NIL);
         link_ra = ADDR_W'(sel_head);
      end
   end
   assign data_ra = ADDR_W'(sel_head);

   // write-back waits while the result register is occupied and not being taken
   assign done     = busy_ff && (!rsp_valid_ff || rsp_tready);
   assign cur_head = head_ff[qi_ff];
   assign cur_tail = tail_ff[qi_ff];
   assign busy_in  = req_fire || (busy_ff && !done);

   always_comb begin
      head_in       = head_ff;
      tail_in       = tail_ff;
      free_head_in  = free_head_ff;
      fill_in       = fill_ff;
      link_we       = 1'b0;
      link_wa       = ADDR_W'(free_head_ff);
      link_wd       = free_head_ff;
      data_we       = 1'b0;
      data_wa       = ADDR_W'(free_head_ff);
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_data_in   = rsp_data_ff;
      rsp_status_in = rsp_status_ff;
      if (done) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = '0;
         if (op_ff == sbmq_pkg::OP_ENQUEUE) begin
            rsp_status_in = ok_ff ? sbmq_pkg::ST_DONE : sbmq_pkg::ST_FULL;
            if (ok_ff) begin
               data_we = 1'b1;
               // append after the tail, or start an empty queue
               if (cur_head < NIL) begin
                  link_we = 1'b1;
                  link_wa = ADDR_W'(cur_tail);
                  link_wd = free_head_ff;
               end else begin
                  head_in[qi_ff] = free_head_ff;
               end
               tail_in[qi_ff] = free_head_ff;
               // a fresh slot still links to its successor, the last one to null
               if (free_head_ff == fill_ff) begin
                  free_head_in = free_head_ff + PTR_W'(1);
                  fill_in      = fill_ff + PTR_W'(1);
               end else begin
                  free_head_in = link_rd;
               end
            end
         end else begin
            rsp_status_in = ok_ff ? sbmq_pkg::ST_DONE : sbmq_pkg::ST_EMPTY;
            if (ok_ff) begin
               rsp_data_in = signed'(data_rd);
               // the tail slot is the end of the queue's list
               head_in[qi_ff] = (cur_head == cur_tail) ? NIL : link_rd;
               link_we        = 1'b1;
               link_wa        = ADDR_W'(cur_head);
               link_wd        = free_head_ff;
               free_head_in   = cur_head;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         free_head_ff <= '0;
         fill_ff      <= '0;
         for (int i = 0; i < QREG; i++) begin
            head_ff[i] <= NIL;
            tail_ff[i] <= NIL;
         end
      end else begin
         busy_ff      <= busy_in;
         rsp_valid_ff <= rsp_valid_in;
         free_head_ff <= free_head_in;
         fill_ff      <= fill_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         op_ff    <= req_op;
         ok_ff    <= req_ok;
         qi_ff    <= req_qi;
         value_ff <= req_value;
      end
      rsp_data_ff   <= rsp_data_in;
      rsp_status_ff <= rsp_status_in;
   end

   // next-slot links, null coded as SLOTS
   sbmq_ram #(
      .WIDTH (PTR_W),
      .DEPTH (SLOTS)
   ) u_link_ram (
      .clock   (clock),
      .wr_en   (link_we),
      .wr_addr (link_wa),
      .wr_data (link_wd),
      .rd_en   (req_fire),
      .rd_addr (link_ra),
      .rd_data (link_rd)
   );

   // slot payload words
   sbmq_ram #(
      .WIDTH (sbmq_pkg::VALUE_W),
      .DEPTH (SLOTS)
   ) u_data_ram (
      .clock   (clock),
      .wr_en   (data_we),
      .wr_addr (data_wa),
      .wr_data (value_ff),
      .rd_en   (req_fire),
      .rd_addr (data_ra),
      .rd_data (data_rd)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_status_ff;

   `SBMQ_ASSERT_SAME(a_free_below_fill, clock, reset, 1'b1, (free_head_ff <= fill_ff) && (fill_ff <= NIL), "free list head beyond fill count")
   `SBMQ_ASSERT_SAME(a_no_write_on_read, clock, reset, link_we || data_we, !req_fire, "ram write in a transfer cycle")
   `SBMQ_ASSERT_NEXT(a_fire_busy, clock, reset, req_fire, busy_ff && !req_tready, "item not held for write-back")
   `SBMQ_ASSERT_NEXT(a_alloc_moves, clock, reset, done && ok_ff && (op_ff == sbmq_pkg::OP_ENQUEUE), free_head_ff != $past(free_head_ff), "free list head did not advance")

endmodule

// File: test/tb_top.sv
module tb_top;
   import sbmq_pkg::*;

   localparam int ITEMS        = 1150;   // rough size of the whole stimulus
   localparam int STEADY_ITEMS = 150;    // closing stretch with no idling
   localparam int LONG_HOLD    = 300;    // receiver hold-off, in cycles
   localparam int STALL_LIMIT  = 4000;   // cycles without any transfer before giving up
   localparam int DRAIN_CYCLES = 20;     // quiet cycles after the last result
   localparam int PRINT_CAP    = 40;     // mismatch lines printed at most

   // predictor of the shared slot store plus the queue of awaited responses
   class linked_queue_scoreboard;
      localparam int NSLOTS  = sbmq_pkg::SLOTS_DEFAULT;
      localparam int NQUEUES = sbmq_pkg::QUEUES_DEFAULT;
      localparam logic [6:0] NIL = 7'(NSLOTS);

      typedef struct {
         logic [31:0] word;
         status_type  status;
      } response_type;

      logic [31:0]  slot_word [NSLOTS];
      logic [6:0]   slot_next [NSLOTS];
      logic [6:0]   q_head [NQUEUES];
      logic [6:0]   q_tail [NQUEUES];
      logic [6:0]   free_slot;
      response_type awaited_responses [$];

      function new();
         for (int i = 0; i < NSLOTS; i++) begin
            slot_word[i] = '0;
            slot_next[i] = 7'(i + 1);
         end
         slot_next[NSLOTS-1] = NIL;
         for (int i = 0; i < NQUEUES; i++) begin
            q_head[i] = NIL;
            q_tail[i] = NIL;
         end
         free_slot = '0;
      endfunction

      function bit holds_slot(logic [6:0] p);
         return p < NIL;
      endfunction

      // advance the predicted store by one accepted request
      function void note_request(op_type op, logic [1:0] qsel, logic [31:0] value);
         response_type r;
         logic [6:0]   s;
         r.word   = '0;
         r.status = ST_DONE;
         if (op == OP_ENQUEUE) begin
            if (!holds_slot(free_slot)) begin
               r.status = ST_FULL;
            end else begin
               s         = free_slot;
               free_slot = slot_next[s];
               // an empty queue rewrites its head; its stale tail is then overwritten
               if (!holds_slot(q_head[qsel]))
                  q_head[qsel] = s;
               else if (holds_slot(q_tail[qsel]))
                  slot_next[q_tail[qsel]] = s;
               slot_next[s] = NIL;
               q_tail[qsel] = s;
               slot_word[s] = value;
            end
         end else begin
            if (!holds_slot(q_head[qsel])) begin
               r.status = ST_EMPTY;
            end else begin
               s            = q_head[qsel];
               q_head[qsel] = slot_next[s];
               slot_next[s] = free_slot;
               free_slot    = s;
               r.word       = slot_word[s];
            end
         end
         awaited_responses.push_back(r);
      endfunction

      // compare one response with the oldest awaited one
      function bit check_response(logic [31:0] word, logic [1:0] status, output string why);
         response_type r;
         why = "";
         if (awaited_responses.size() == 0) begin
            $sformat(why, "response with nothing awaited: data %h status %0d", word, status);
            return 1'b0;
         end
         r = awaited_responses.pop_front();
         if (word !== r.word || status !== r.status) begin
            $sformat(why, "response data %h status %0d, awaited data %h status %0d",
                     word, status, r.word, r.status);
            return 1'b0;
         end
         return 1'b1;
      endfunction

      function int outstanding();
         return awaited_responses.size();
      endfunction
   endclass

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [39:0] req_tdata  = '0;   // queue_select [1:0], value [33:2], zero fill [39:34]
   logic        req_tuser  = 1'b0; // operation [0]
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;         // data [31:0]
   logic [1:0]  rsp_tuser;         // status [1:0]

   linked_queue_scoreboard sb = new();

   int mismatches    = 0;
   int items_sent    = 0;
   int hold_requests = 0;    // bumped by the sender to ask the receiver for a long hold-off
   bit steady        = 1'b0; // no idling on either side once set
   int idle_cycles   = 0;

   logic [31:0] corner_words [4] = '{32'h0000_0000, 32'hffff_ffff,
                                     32'h8000_0000, 32'h7fff_ffff};

   always #4 clock = ~clock;

   shared_buffer_multi_queue_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   task automatic report_mismatch(string why);
      mismatches++;
      if (mismatches <= PRINT_CAP)
         $display("mismatch at %0t: %s", $realtime, why);
   endtask

   // offer one request and hold it until the transfer; sometimes idle afterwards
   task automatic send_request(op_type op, logic [1:0] qsel, logic [31:0] value);
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {6'b0, value, qsel};
      do @(posedge clock); while (!req_tready);
      sb.note_request(op, qsel, value);
      items_sent++;
      if (!steady && $urandom_range(0, 5) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 17)) @(posedge clock);
      end
   endtask

   // stop offering until every awaited response has come back
   task automatic settle();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (sb.outstanding() != 0);
   endtask

   // enq_weight out of 8 requests are enqueues; fixed_q < 0 picks queues at random
   task automatic run_random_block(int count, int enq_weight, int fixed_q);
      op_type      op;
      logic [1:0]  qsel;
      logic [31:0] value;
      for (int i = 0; i < count; i++) begin
         op    = ($urandom_range(0, 7) < enq_weight) ? OP_ENQUEUE : OP_DEQUEUE;
         qsel  = (fixed_q < 0) ? 2'($urandom_range(0, 3)) : 2'(fixed_q);
         value = ($urandom_range(0, 15) == 0) ? corner_words[$urandom_range(0, 3)] : $urandom;
         send_request(op, qsel, value);
      end
   endtask

   // stimulus
   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // every queue empty after reset
      send_request(OP_DEQUEUE, 2'd0, 32'hdead_beef);
      send_request(OP_DEQUEUE, 2'd1, 32'h0000_0000);
      send_request(OP_DEQUEUE, 2'd2, 32'hffff_ffff);
      send_request(OP_DEQUEUE, 2'd3, 32'h1234_5678);
      // value extremes spread over the queues
      send_request(OP_ENQUEUE, 2'd0, 32'h7fff_ffff);
      send_request(OP_ENQUEUE, 2'd0, 32'h8000_0000);
      send_request(OP_ENQUEUE, 2'd1, 32'h0000_0000);
      send_request(OP_ENQUEUE, 2'd2, 32'hffff_ffff);
      send_request(OP_ENQUEUE, 2'd3, 32'h5555_5555);
      send_request(OP_ENQUEUE, 2'd3, 32'haaaa_aaaa);
      // fifo order, then empty queue 0 leaving its tail stale
      send_request(OP_DEQUEUE, 2'd0, 32'h0000_0000);
      send_request(OP_DEQUEUE, 2'd0, 32'h0000_0000);
      send_request(OP_DEQUEUE, 2'd0, 32'h0000_0000);
      // enqueue into the emptied queue must ignore the stale tail
      send_request(OP_ENQUEUE, 2'd0, 32'h1357_9bdf);
      send_request(OP_DEQUEUE, 2'd0, 32'h0000_0000);
      // drain the rest, past empty
      send_request(OP_DEQUEUE, 2'd1, 32'h0000_0000);
      send_request(OP_DEQUEUE, 2'd2, 32'h0000_0000);
      send_request(OP_DEQUEUE, 2'd3, 32'h0000_0000);
      send_request(OP_DEQUEUE, 2'd3, 32'h0000_0000);
      send_request(OP_DEQUEUE, 2'd2, 32'h0000_0000);

      // fill the whole store past full, then dequeue from random queues
      run_random_block(70, 8, -1);
      run_random_block(80, 0, -1);

      // long receiver hold-off while requests keep coming
      hold_requests <= hold_requests + 1;
      run_random_block(40, 6, -1);
      // sender waits for every response
      settle();

      while (items_sent < ITEMS - STEADY_ITEMS) begin
         case ($urandom_range(0, 3))
            0: run_random_block($urandom_range(20, 60), 7, -1);
            1: run_random_block($urandom_range(20, 60), 1, -1);
            2: run_random_block($urandom_range(20, 60), 4, -1);
            default: run_random_block($urandom_range(20, 60), 4, $urandom_range(0, 3));
         endcase
      end

      // closing stretch at full rate
      steady <= 1'b1;
      run_random_block(STEADY_ITEMS / 2, 6, -1);
      run_random_block(STEADY_ITEMS / 2, 2, -1);

      req_tvalid <= 1'b0;
      do @(posedge clock); while (sb.outstanding() != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0)
         $display("shared_buffer_multi_queue_unit verification clean");
      else
         $display("shared_buffer_multi_queue_unit verification failed");
      $finish;
   end

   // receiver: random stall bursts, plus the long hold-off on request
   initial begin : receiver
      int holds_done;
      holds_done = 0;
      while (reset) @(posedge clock);
      forever begin
         if (hold_requests != holds_done) begin
            rsp_tready <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
            holds_done++;
         end else if (!steady && $urandom_range(0, 5) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge clock);
         end else begin
            rsp_tready <= 1'b1;
            @(posedge clock);
         end
      end
   end

   // response checker
   always @(posedge clock) begin : response_check
      string why;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (!sb.check_response(rsp_tdata, rsp_tuser, why))
            report_mismatch(why);
      end
   end

   // watchdog: too long without any transfer on either side
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
         $display("shared_buffer_multi_queue_unit verification failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

endmodule
